FILE: sv/kvdb_pkg.sv
// Package for the key-frame vertex decode and blend block.
// Holds widths, register indexes and the 162-entry unit-normal table.
// No dependencies.
package kvdb_pkg;

    localparam int NORMAL_COUNT = 162;
    localparam int BLEND_ONE    = 65536;

    typedef enum logic [2:0] {
        REG_SRC_X = 3'd0,
        REG_SRC_Y = 3'd1,
        REG_SRC_Z = 3'd2,
        REG_DST_X = 3'd3,
        REG_DST_Y = 3'd4,
        REG_DST_Z = 3'd5,
        REG_BLEND = 3'd6,
        REG_FLIP  = 3'd7
    } reg_idx_t;

    typedef logic signed [15:0] q14_t;
    typedef struct packed {
        q14_t x;
        q14_t y;
        q14_t z;
    } normal_t;

    localparam logic signed [15:0] M1 = 16'sd16384, M525 = 16'sd8614, M850 = 16'sd13937,
        M955 = 16'sd15654, M295 = 16'sd4837, M162 = 16'sd2662, M262 = 16'sd4307,
        M442 = 16'sd7256, M238 = 16'sd3913, M864 = 16'sd14159, M309 = 16'sd5063,
        M500 = 16'sd8192, M809 = 16'sd13255, M951 = 16'sd15582, M147 = 16'sd2419,
        M716 = 16'sd11740, M681 = 16'sd11169, M587 = 16'sd9630, M425 = 16'sd6969,
        M688 = 16'sd11275, Z = 16'sd0;

    function automatic normal_t nv(input q14_t a, input q14_t b, input q14_t c);
        normal_t r;
        r.x = a;
        r.y = b;
        r.z = c;
        return r;
    endfunction

    function automatic normal_t normal_lut(input logic [7:0] i);
        normal_t r;
        r = nv(Z, Z, Z);
        case (i)
            8'd0: r = nv(-M525,Z,M850);       8'd1: r = nv(-M442,M238,M864);
            8'd2: r = nv(-M295,Z,M955);       8'd3: r = nv(-M309,M500,M809);
            8'd4: r = nv(-M162,M262,M951);    8'd5: r = nv(Z,Z,M1);
            8'd6: r = nv(Z,M850,M525);        8'd7: r = nv(-M147,M716,M681);
            8'd8: r = nv(M147,M716,M681);     8'd9: r = nv(Z,M525,M850);
            8'd10: r = nv(M309,M500,M809);    8'd11: r = nv(M525,Z,M850);
            8'd12: r = nv(M295,Z,M955);       8'd13: r = nv(M442,M238,M864);
            8'd14: r = nv(M162,M262,M951);    8'd15: r = nv(-M681,M147,M716);
            8'd16: r = nv(-M809,M309,M500);   8'd17: r = nv(-M587,M425,M688);
            8'd18: r = nv(-M850,M525,Z);      8'd19: r = nv(-M864,M442,M238);
            8'd20: r = nv(-M716,M681,M147);   8'd21: r = nv(-M688,M587,M425);
            8'd22: r = nv(-M500,M809,M309);   8'd23: r = nv(-M238,M864,M442);
            8'd24: r = nv(-M425,M688,M587);   8'd25: r = nv(-M716,M681,-M147);
            8'd26: r = nv(-M500,M809,-M309);  8'd27: r = nv(-M525,M850,Z);
            8'd28: r = nv(Z,M850,-M525);      8'd29: r = nv(-M238,M864,-M442);
            8'd30: r = nv(Z,M955,-M295);      8'd31: r = nv(-M262,M951,-M162);
            8'd32: r = nv(Z,M1,Z);            8'd33: r = nv(Z,M955,M295);
            8'd34: r = nv(-M262,M951,M162);   8'd35: r = nv(M238,M864,M442);
            8'd36: r = nv(M262,M951,M162);    8'd37: r = nv(M500,M809,M309);
            8'd38: r = nv(M238,M864,-M442);   8'd39: r = nv(M262,M951,-M162);
            8'd40: r = nv(M500,M809,-M309);   8'd41: r = nv(M850,M525,Z);
            8'd42: r = nv(M716,M681,M147);    8'd43: r = nv(M716,M681,-M147);
            8'd44: r = nv(M525,M850,Z);       8'd45: r = nv(M425,M688,M587);
            8'd46: r = nv(M864,M442,M238);    8'd47: r = nv(M688,M587,M425);
            8'd48: r = nv(M809,M309,M500);    8'd49: r = nv(M681,M147,M716);
            8'd50: r = nv(M587,M425,M688);    8'd51: r = nv(M955,M295,Z);
            8'd52: r = nv(M1,Z,Z);            8'd53: r = nv(M951,M162,M262);
            8'd54: r = nv(M850,-M525,Z);      8'd55: r = nv(M955,-M295,Z);
            8'd56: r = nv(M864,-M442,M238);   8'd57: r = nv(M951,-M162,M262);
            8'd58: r = nv(M809,-M309,M500);   8'd59: r = nv(M681,-M147,M716);
            8'd60: r = nv(M850,Z,M525);       8'd61: r = nv(M864,M442,-M238);
            8'd62: r = nv(M809,M309,-M500);   8'd63: r = nv(M951,M162,-M262);
            8'd64: r = nv(M525,Z,-M850);      8'd65: r = nv(M681,M147,-M716);
            8'd66: r = nv(M681,-M147,-M716);  8'd67: r = nv(M850,Z,-M525);
            8'd68: r = nv(M809,-M309,-M500);  8'd69: r = nv(M864,-M442,-M238);
            8'd70: r = nv(M951,-M162,-M262);  8'd71: r = nv(M147,M716,-M681);
            8'd72: r = nv(M309,M500,-M809);   8'd73: r = nv(M425,M688,-M587);
            8'd74: r = nv(M442,M238,-M864);   8'd75: r = nv(M587,M425,-M688);
            8'd76: r = nv(M688,M587,-M425);   8'd77: r = nv(-M147,M716,-M681);
            8'd78: r = nv(-M309,M500,-M809);  8'd79: r = nv(Z,M525,-M850);
            8'd80: r = nv(-M525,Z,-M850);     8'd81: r = nv(-M442,M238,-M864);
            8'd82: r = nv(-M295,Z,-M955);     8'd83: r = nv(-M162,M262,-M951);
            8'd84: r = nv(Z,Z,-M1);           8'd85: r = nv(M295,Z,-M955);
            8'd86: r = nv(M162,M262,-M951);   8'd87: r = nv(-M442,-M238,-M864);
            8'd88: r = nv(-M309,-M500,-M809); 8'd89: r = nv(-M162,-M262,-M951);
            8'd90: r = nv(Z,-M850,-M525);     8'd91: r = nv(-M147,-M716,-M681);
            8'd92: r = nv(M147,-M716,-M681);  8'd93: r = nv(Z,-M525,-M850);
            8'd94: r = nv(M309,-M500,-M809);  8'd95: r = nv(M442,-M238,-M864);
            8'd96: r = nv(M162,-M262,-M951);  8'd97: r = nv(M238,-M864,-M442);
            8'd98: r = nv(M500,-M809,-M309);  8'd99: r = nv(M425,-M688,-M587);
            8'd100: r = nv(M716,-M681,-M147); 8'd101: r = nv(M688,-M587,-M425);
            8'd102: r = nv(M587,-M425,-M688); 8'd103: r = nv(Z,-M955,-M295);
            8'd104: r = nv(Z,-M1,Z);          8'd105: r = nv(M262,-M951,-M162);
            8'd106: r = nv(Z,-M850,M525);     8'd107: r = nv(Z,-M955,M295);
            8'd108: r = nv(M238,-M864,M442);  8'd109: r = nv(M262,-M951,M162);
            8'd110: r = nv(M500,-M809,M309);  8'd111: r = nv(M716,-M681,M147);
            8'd112: r = nv(M525,-M850,Z);     8'd113: r = nv(-M238,-M864,-M442);
            8'd114: r = nv(-M500,-M809,-M309);8'd115: r = nv(-M262,-M951,-M162);
            8'd116: r = nv(-M850,-M525,Z);    8'd117: r = nv(-M716,-M681,-M147);
            8'd118: r = nv(-M716,-M681,M147); 8'd119: r = nv(-M525,-M850,Z);
            8'd120: r = nv(-M500,-M809,M309); 8'd121: r = nv(-M238,-M864,M442);
            8'd122: r = nv(-M262,-M951,M162); 8'd123: r = nv(-M864,-M442,M238);
            8'd124: r = nv(-M809,-M309,M500); 8'd125: r = nv(-M688,-M587,M425);
            8'd126: r = nv(-M681,-M147,M716); 8'd127: r = nv(-M442,-M238,M864);
            8'd128: r = nv(-M587,-M425,M688); 8'd129: r = nv(-M309,-M500,M809);
            8'd130: r = nv(-M147,-M716,M681); 8'd131: r = nv(-M425,-M688,M587);
            8'd132: r = nv(-M162,-M262,M951); 8'd133: r = nv(M442,-M238,M864);
            8'd134: r = nv(M162,-M262,M951);  8'd135: r = nv(M309,-M500,M809);
            8'd136: r = nv(M147,-M716,M681);  8'd137: r = nv(Z,-M525,M850);
            8'd138: r = nv(M425,-M688,M587);  8'd139: r = nv(M587,-M425,M688);
            8'd140: r = nv(M688,-M587,M425);  8'd141: r = nv(-M955,M295,Z);
            8'd142: r = nv(-M951,M162,M262);  8'd143: r = nv(-M1,Z,Z);
            8'd144: r = nv(-M850,Z,M525);     8'd145: r = nv(-M955,-M295,Z);
            8'd146: r = nv(-M951,-M162,M262); 8'd147: r = nv(-M864,M442,-M238);
            8'd148: r = nv(-M951,M162,-M262); 8'd149: r = nv(-M809,M309,-M500);
            8'd150: r = nv(-M864,-M442,-M238);8'd151: r = nv(-M951,-M162,-M262);
            8'd152: r = nv(-M809,-M309,-M500);8'd153: r = nv(-M681,M147,-M716);
            8'd154: r = nv(-M681,-M147,-M716);8'd155: r = nv(-M850,Z,-M525);
            8'd156: r = nv(-M688,M587,-M425); 8'd157: r = nv(-M587,M425,-M688);
            8'd158: r = nv(-M425,M688,-M587); 8'd159: r = nv(-M425,-M688,-M587);
            8'd160: r = nv(-M587,-M425,-M688);8'd161: r = nv(-M688,-M587,-M425);
            default: r = nv(Z,Z,Z);
        endcase
        return r;
    endfunction

endpackage

FILE: sv/kvdb_pos_lane.sv
// One position lane: decodes both frames' coordinate and blends them.
// Three register stages: decode, blend multiply, round and saturate.
// Depends on kvdb_pkg.
module kvdb_pos_lane
    import kvdb_pkg::*;
(
    input  logic               clk,
    input  logic               en0,
    input  logic               en1,
    input  logic               en2,
    input  logic [63:0]        src_xf,
    input  logic [63:0]        dst_xf,
    input  logic [7:0]         src_byte,
    input  logic [7:0]         dst_byte,
    input  logic [16:0]        blend,
    output logic signed [31:0] pos
);

    // decoded values need 41 bits; difference 42
    logic signed [40:0] s_reg, s_next, d_reg, d_next;
    logic signed [40:0] s1_reg;
    logic signed [59:0] p_reg, p_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [41:0] diff;
    logic signed [59:0] biased;
    logic signed [43:0] q;
    logic signed [44:0] v;

    always_comb
    begin
        s_next = 41'($signed(src_xf[63:32]) * $signed({1'b0, src_byte}))
               + 41'($signed(src_xf[31:0]));
        d_next = 41'($signed(dst_xf[63:32]) * $signed({1'b0, dst_byte}))
               + 41'($signed(dst_xf[31:0]));
    end

    // 42 x 18 product, split by the blend stage register
    always_comb
    begin
        diff   = 42'(d_reg) - 42'(s_reg);
        p_next = 60'(diff * $signed({1'b0, blend}));
    end

    always_comb
    begin
        biased = p_reg + 60'sd32768;
        q      = 44'(biased >>> 16);
        v      = 45'(s1_reg) + 45'(q);
        if (v > 45'sd2147483647)
            pos_next = 32'sh7fffffff;
        else if (v < -45'sd2147483648)
            pos_next = 32'sh80000000;
        else
            pos_next = v[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s_reg <= s_next;
            d_reg <= d_next;
        end
        if (en1)
        begin
            s1_reg <= s_reg;
            p_reg  <= p_next;
        end
        if (en2)
            pos_reg <= pos_next;
    end

    assign pos = pos_reg;

endmodule

FILE: sv/kvdb_norm_lane.sv
// One normal lane: blends one component of the two looked-up normals.
// Stages line up with the position lanes. Depends on kvdb_pkg.
module kvdb_norm_lane
    import kvdb_pkg::*;
(
    input  logic        clk,
    input  logic        en1,
    input  logic        en2,
    input  q14_t        s_val,
    input  q14_t        d_val,
    input  logic [16:0] blend,
    output q14_t        norm_raw
);

    q14_t               s1_reg;
    logic signed [34:0] p_reg, p_next;
    q14_t               n_reg, n_next;
    logic signed [34:0] biased;
    logic signed [18:0] q;

    always_comb
    begin
        p_next = 35'((17'(d_val) - 17'(s_val)) * $signed({1'b0, blend}));
        biased = p_reg + 35'sd32768;
        q      = 19'(biased >>> 16);
        n_next = 16'(19'(s1_reg) + q);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s_val;
            p_reg  <= p_next;
        end
        if (en2)
            n_reg <= n_next;
    end

    assign norm_raw = n_reg;

endmodule

FILE: sv/keyframe_vertex_decode_blend.sv
// Key-frame vertex decode and blend, top level.
// Stages from accepted start to done: lookup/decode, multiply, round.
// Throughput: one vertex per cycle; busy is never asserted. Three position lanes
// and three normal lanes run side by side; the output stage merges the flags.
// Reset: transforms return to scale 1.0, translate 0; blend 0, flip off.
// The receiver cannot stall; done is high for exactly one cycle per result.
module keyframe_vertex_decode_blend
    import kvdb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic [7:0]         src_x,
    input  logic [7:0]         src_y,
    input  logic [7:0]         src_z,
    input  logic [7:0]         src_normal,
    input  logic [7:0]         dst_x,
    input  logic [7:0]         dst_y,
    input  logic [7:0]         dst_z,
    input  logic [7:0]         dst_normal,
    output logic               done,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic               bad_normal
);

    localparam logic [63:0] XF_RESET = 64'h0001_0000_0000_0000;

    logic [63:0] xf_reg [6];
    logic [16:0] blend_reg;
    logic        flip_reg;
    logic [16:0] blend_eff;
    logic [2:0]  vld_reg;
    logic [2:0]  bad_reg;
    logic [1:0]  flip_pipe_reg;
    normal_t     sn_reg, dn_reg;
    logic        bad_in;
    logic signed [31:0] pos_w [3];
    q14_t        nraw [3];
    q14_t        s_comp [3], d_comp [3];
    logic [7:0]  sb [3], db [3];

    assign busy = 1'b0;
    assign blend_eff = (blend_reg > 17'(BLEND_ONE)) ? 17'(BLEND_ONE) : blend_reg;
    assign bad_in = (src_normal >= 8'(NORMAL_COUNT)) || (dst_normal >= 8'(NORMAL_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                xf_reg[i] <= XF_RESET;
            blend_reg     <= '0;
            flip_reg      <= 1'b0;
            vld_reg       <= '0;
            bad_reg       <= '0;
            flip_pipe_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_SRC_X: xf_reg[0] <= cfg_data;
                    REG_SRC_Y: xf_reg[1] <= cfg_data;
                    REG_SRC_Z: xf_reg[2] <= cfg_data;
                    REG_DST_X: xf_reg[3] <= cfg_data;
                    REG_DST_Y: xf_reg[4] <= cfg_data;
                    REG_DST_Z: xf_reg[5] <= cfg_data;
                    REG_BLEND: blend_reg <= cfg_data[16:0];
                    REG_FLIP:  flip_reg  <= cfg_data[0];
                    default:   ;
                endcase
            end
            vld_reg       <= {vld_reg[1:0], start};
            bad_reg       <= {bad_reg[1:0], bad_in};
            flip_pipe_reg <= {flip_pipe_reg[0], flip_reg};
        end
    end

    // normal lookup shares stage 0 with coordinate decode
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sn_reg <= normal_lut(src_normal);
            dn_reg <= normal_lut(dst_normal);
        end
    end

    assign sb[0] = src_x; assign sb[1] = src_y; assign sb[2] = src_z;
    assign db[0] = dst_x; assign db[1] = dst_y; assign db[2] = dst_z;
    assign s_comp[0] = sn_reg.x; assign s_comp[1] = sn_reg.y; assign s_comp[2] = sn_reg.z;
    assign d_comp[0] = dn_reg.x; assign d_comp[1] = dn_reg.y; assign d_comp[2] = dn_reg.z;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        kvdb_pos_lane u_pos (
            .clk      (clk),
            .en0      (start),
            .en1      (vld_reg[0]),
            .en2      (vld_reg[1]),
            .src_xf   (xf_reg[k]),
            .dst_xf   (xf_reg[k + 3]),
            .src_byte (sb[k]),
            .dst_byte (db[k]),
            .blend    (blend_eff),
            .pos      (pos_w[k])
        );
        kvdb_norm_lane u_norm (
            .clk      (clk),
            .en1      (vld_reg[0]),
            .en2      (vld_reg[1]),
            .s_val    (s_comp[k]),
            .d_val    (d_comp[k]),
            .blend    (blend_eff),
            .norm_raw (nraw[k])
        );
    end

    // merge: bad index zeroes normals, flip negates
    function automatic q14_t fix_norm(input q14_t n, input logic bad, input logic flip);
        q14_t r;
        r = bad ? 16'sd0 : (flip ? -n : n);
        return r;
    endfunction

    assign done       = vld_reg[2];
    assign pos_x      = pos_w[0];
    assign pos_y      = pos_w[1];
    assign pos_z      = pos_w[2];
    assign norm_x     = fix_norm(nraw[0], bad_reg[2], flip_pipe_reg[1]);
    assign norm_y     = fix_norm(nraw[1], bad_reg[2], flip_pipe_reg[1]);
    assign norm_z     = fix_norm(nraw[2], bad_reg[2], flip_pipe_reg[1]);
    assign bad_normal = bad_reg[2];

endmodule

FILE: tb/testbench.sv
// Testbench for keyframe_vertex_decode_blend: directed vertices, then random ones.
// Results are checked against a predictor held here; depends on kvdb_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import kvdb_pkg::*;

    typedef struct packed {
        logic [7:0] sx, sy, sz, sn, dx, dy, dz, dn;
    } vertex_in_t;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic               bad;
    } vertex_out_t;

    typedef struct packed {
        vertex_in_t  v;
        logic        known;
        vertex_out_t want;
    } dir_row_t;

    logic               clk, rst_n, start, cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic [7:0]         src_x, src_y, src_z, src_normal, dst_x, dst_y, dst_z, dst_normal;
    logic               busy, done, bad_normal;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;

    keyframe_vertex_decode_blend i_dut (.*);

    // predictor copy of the registers
    logic [63:0] xf_cfg [6];
    logic [16:0] blend_cfg;
    logic        flip_cfg;

    vertex_out_t pending_vertices [$];
    int          mismatches;
    int          accepted_cnt;

    // unit normals, Q1.14
    int unit_tab [162][3] = '{
        '{-M525,0,M850},'{-M442,M238,M864},'{-M295,0,M955},'{-M309,M500,M809},
        '{-M162,M262,M951},'{0,0,M1},'{0,M850,M525},'{-M147,M716,M681},
        '{M147,M716,M681},'{0,M525,M850},'{M309,M500,M809},'{M525,0,M850},
        '{M295,0,M955},'{M442,M238,M864},'{M162,M262,M951},'{-M681,M147,M716},
        '{-M809,M309,M500},'{-M587,M425,M688},'{-M850,M525,0},'{-M864,M442,M238},
        '{-M716,M681,M147},'{-M688,M587,M425},'{-M500,M809,M309},'{-M238,M864,M442},
        '{-M425,M688,M587},'{-M716,M681,-M147},'{-M500,M809,-M309},'{-M525,M850,0},
        '{0,M850,-M525},'{-M238,M864,-M442},'{0,M955,-M295},'{-M262,M951,-M162},
        '{0,M1,0},'{0,M955,M295},'{-M262,M951,M162},'{M238,M864,M442},
        '{M262,M951,M162},'{M500,M809,M309},'{M238,M864,-M442},'{M262,M951,-M162},
        '{M500,M809,-M309},'{M850,M525,0},'{M716,M681,M147},'{M716,M681,-M147},
        '{M525,M850,0},'{M425,M688,M587},'{M864,M442,M238},'{M688,M587,M425},
        '{M809,M309,M500},'{M681,M147,M716},'{M587,M425,M688},'{M955,M295,0},
        '{M1,0,0},'{M951,M162,M262},'{M850,-M525,0},'{M955,-M295,0},
        '{M864,-M442,M238},'{M951,-M162,M262},'{M809,-M309,M500},'{M681,-M147,M716},
        '{M850,0,M525},'{M864,M442,-M238},'{M809,M309,-M500},'{M951,M162,-M262},
        '{M525,0,-M850},'{M681,M147,-M716},'{M681,-M147,-M716},'{M850,0,-M525},
        '{M809,-M309,-M500},'{M864,-M442,-M238},'{M951,-M162,-M262},'{M147,M716,-M681},
        '{M309,M500,-M809},'{M425,M688,-M587},'{M442,M238,-M864},'{M587,M425,-M688},
        '{M688,M587,-M425},'{-M147,M716,-M681},'{-M309,M500,-M809},'{0,M525,-M850},
        '{-M525,0,-M850},'{-M442,M238,-M864},'{-M295,0,-M955},'{-M162,M262,-M951},
        '{0,0,-M1},'{M295,0,-M955},'{M162,M262,-M951},'{-M442,-M238,-M864},
        '{-M309,-M500,-M809},'{-M162,-M262,-M951},'{0,-M850,-M525},'{-M147,-M716,-M681},
        '{M147,-M716,-M681},'{0,-M525,-M850},'{M309,-M500,-M809},'{M442,-M238,-M864},
        '{M162,-M262,-M951},'{M238,-M864,-M442},'{M500,-M809,-M309},'{M425,-M688,-M587},
        '{M716,-M681,-M147},'{M688,-M587,-M425},'{M587,-M425,-M688},'{0,-M955,-M295},
        '{0,-M1,0},'{M262,-M951,-M162},'{0,-M850,M525},'{0,-M955,M295},
        '{M238,-M864,M442},'{M262,-M951,M162},'{M500,-M809,M309},'{M716,-M681,M147},
        '{M525,-M850,0},'{-M238,-M864,-M442},'{-M500,-M809,-M309},'{-M262,-M951,-M162},
        '{-M850,-M525,0},'{-M716,-M681,-M147},'{-M716,-M681,M147},'{-M525,-M850,0},
        '{-M500,-M809,M309},'{-M238,-M864,M442},'{-M262,-M951,M162},'{-M864,-M442,M238},
        '{-M809,-M309,M500},'{-M688,-M587,M425},'{-M681,-M147,M716},'{-M442,-M238,M864},
        '{-M587,-M425,M688},'{-M309,-M500,M809},'{-M147,-M716,M681},'{-M425,-M688,M587},
        '{-M162,-M262,M951},'{M442,-M238,M864},'{M162,-M262,M951},'{M309,-M500,M809},
        '{M147,-M716,M681},'{0,-M525,M850},'{M425,-M688,M587},'{M587,-M425,M688},
        '{M688,-M587,M425},'{-M955,M295,0},'{-M951,M162,M262},'{-M1,0,0},
        '{-M850,0,M525},'{-M955,-M295,0},'{-M951,-M162,M262},'{-M864,M442,-M238},
        '{-M951,M162,-M262},'{-M809,M309,-M500},'{-M864,-M442,-M238},'{-M951,-M162,-M262},
        '{-M809,-M309,-M500},'{-M681,M147,-M716},'{-M681,-M147,-M716},'{-M850,0,-M525},
        '{-M688,M587,-M425},'{-M587,M425,-M688},'{-M425,M688,-M587},'{-M425,-M688,-M587},
        '{-M587,-M425,-M688},'{-M688,-M587,-M425}
    };

    // known rows assume the reset registers: scale 1.0, translate 0, blend 0
    dir_row_t vertex_rows [14] = '{
        '{'{8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0}, 1'b1,
          '{32'sd0,32'sd0,32'sd0,-16'sd8614,16'sd0,16'sd13937,1'b0}},
        '{'{8'hFF,8'hFF,8'hFF,8'd5,8'd0,8'd0,8'd0,8'd0}, 1'b1,
          '{32'sh00FF0000,32'sh00FF0000,32'sh00FF0000,16'sd0,16'sd0,16'sd16384,1'b0}},
        '{'{8'h01,8'h80,8'h7F,8'd162,8'd0,8'd0,8'd0,8'd0}, 1'b1,
          '{32'sh00010000,32'sh00800000,32'sh007F0000,16'sd0,16'sd0,16'sd0,1'b1}},
        '{'{8'd0,8'd0,8'd0,8'd0,8'hFF,8'hFF,8'hFF,8'd162}, 1'b1,
          '{32'sd0,32'sd0,32'sd0,16'sd0,16'sd0,16'sd0,1'b1}},
        '{'{8'd0,8'd0,8'd0,8'd255,8'd0,8'd0,8'd0,8'd255}, 1'b1,
          '{32'sd0,32'sd0,32'sd0,16'sd0,16'sd0,16'sd0,1'b1}},
        '{'{8'd2,8'd3,8'd4,8'd52,8'd9,8'd9,8'd9,8'd143}, 1'b1,
          '{32'sh00020000,32'sh00030000,32'sh00040000,16'sd16384,16'sd0,16'sd0,1'b0}},
        '{'{8'd0,8'd0,8'd0,8'd161,8'd0,8'd0,8'd0,8'd161}, 1'b0, '0},
        '{'{8'd10,8'd20,8'd30,8'd32,8'd40,8'd50,8'd60,8'd104}, 1'b0, '0},
        '{'{8'hFF,8'h00,8'hFF,8'd84,8'h00,8'hFF,8'h00,8'd5}, 1'b0, '0},
        '{'{8'h55,8'hAA,8'h55,8'd161,8'hAA,8'h55,8'hAA,8'd0}, 1'b0, '0},
        '{'{8'd1,8'd1,8'd1,8'd0,8'd254,8'd254,8'd254,8'd163}, 1'b0, '0},
        '{'{8'd128,8'd128,8'd128,8'd100,8'd127,8'd127,8'd127,8'd60}, 1'b0, '0},
        '{'{8'hFF,8'hFF,8'hFF,8'd255,8'hFF,8'hFF,8'hFF,8'd0}, 1'b0, '0},
        '{'{8'h00,8'h00,8'h00,8'd0,8'hFF,8'hFF,8'hFF,8'd161}, 1'b0, '0}
    };

    function automatic longint decode_axis(logic [63:0] xf, logic [7:0] code);
        longint scl, trn;
        scl = longint'($signed(xf[63:32]));
        trn = longint'($signed(xf[31:0]));
        return scl * longint'({1'b0, code}) + trn;
    endfunction

    // s + round(b*(d-s)/2^16), half up
    function automatic longint lerp_q16(longint s, longint d, longint b);
        longint p;
        p = b * (d - s);
        return s + ((p + 64'sd32768) >>> 16);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic vertex_out_t blend_vertex(vertex_in_t v);
        vertex_out_t r;
        logic [7:0]  sc [3];
        logic [7:0]  dc [3];
        longint      b, n;
        logic signed [31:0] p [3];
        logic signed [15:0] nrm [3];
        sc = '{v.sx, v.sy, v.sz};
        dc = '{v.dx, v.dy, v.dz};
        b = (blend_cfg > 17'd65536) ? 65536 : longint'(blend_cfg);
        r.bad = (v.sn >= NORMAL_COUNT) || (v.dn >= NORMAL_COUNT);
        for (int k = 0; k < 3; k++)
        begin
            p[k] = clamp32(lerp_q16(decode_axis(xf_cfg[k], sc[k]),
                                    decode_axis(xf_cfg[3 + k], dc[k]), b));
            n = 0;
            if (!r.bad)
            begin
                n = lerp_q16(unit_tab[v.sn][k], unit_tab[v.dn][k], b);
                if (flip_cfg) n = -n;
            end
            nrm[k] = n[15:0];
        end
        r.px = p[0]; r.py = p[1]; r.pz = p[2];
        r.nx = nrm[0]; r.ny = nrm[1]; r.nz = nrm[2];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // requests accepted and results checked on the same edge; no result can
    // come back in the cycle of its own request
    always @(posedge clk)
    begin
        vertex_out_t got, want;
        if (rst_n && done)
        begin
            got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, bad_normal};
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("%0t: result with nothing pending", $realtime);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: exp pos %0d %0d %0d nrm %0d %0d %0d bad %0b",
                                 $realtime, want.px, want.py, want.pz, want.nx, want.ny,
                                 want.nz, want.bad);
                        $display("%0t: got pos %0d %0d %0d nrm %0d %0d %0d bad %0b",
                                 $realtime, got.px, got.py, got.pz, got.nx, got.ny,
                                 got.nz, got.bad);
                    end
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            pending_vertices.push_back(blend_vertex('{src_x, src_y, src_z, src_normal,
                                                      dst_x, dst_y, dst_z, dst_normal}));
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    task automatic send_vertex(vertex_in_t v);
        int n;
        n = accepted_cnt;
        start      <= 1'b1;
        src_x      <= v.sx; src_y <= v.sy; src_z <= v.sz; src_normal <= v.sn;
        dst_x      <= v.dx; dst_y <= v.dy; dst_z <= v.dz; dst_normal <= v.dn;
        wait (accepted_cnt != n);
    endtask

    task automatic sender_gap();
        int r, g;
        r = $urandom_range(0, 99);
        g = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (pending_vertices.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // write enable drops for one cycle between writes
    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BLEND) blend_cfg = val[16:0];
        else if (idx == REG_FLIP) flip_cfg = val[0];
        else xf_cfg[idx] = val;
        @(posedge clk);
    endtask

    function automatic vertex_in_t random_vertex();
        vertex_in_t v;
        v = vertex_in_t'({$urandom, $urandom});
        // mostly valid normal indices, the rest anything
        if ($urandom_range(0, 9) < 8) v.sn = $urandom_range(0, NORMAL_COUNT - 1);
        if ($urandom_range(0, 9) < 8) v.dn = $urandom_range(0, NORMAL_COUNT - 1);
        return v;
    endfunction

    function automatic logic [63:0] random_xf(int kind);
        case (kind)
            0: return {$urandom, $urandom};
            1: return {32'h7FFFFFFF, 32'h7FFFFFFF};
            2: return {32'h80000000, 32'h80000000};
            3: return {32'h00000000, $urandom};
            default: return {$urandom_range(0, 32'h0003FFFF) - 32'h00020000,
                             $urandom_range(0, 32'h00FFFFFF) - 32'h00800000};
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start <= 1'b0; cfg_we <= 1'b0; cfg_index <= REG_SRC_X; cfg_data <= '0;
        src_x <= '0; src_y <= '0; src_z <= '0; src_normal <= '0;
        dst_x <= '0; dst_y <= '0; dst_z <= '0; dst_normal <= '0;
        mismatches = 0;
        accepted_cnt = 0;
        for (int k = 0; k < 6; k++) xf_cfg[k] = 64'h0001_0000_0000_0000;
        blend_cfg = '0;
        flip_cfg  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vertex_rows[i])
        begin
            if (vertex_rows[i].known && blend_vertex(vertex_rows[i].v) !== vertex_rows[i].want)
            begin
                mismatches++;
                $display("vertex row %0d: predictor disagrees with typed result", i);
            end
            send_vertex(vertex_rows[i].v);
        end
        drain();

        // extremes of blend and transforms, then random settings
        for (int ph = 0; ph < 10; ph++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(reg_idx_t'(r), random_xf(ph < 3 ? ph : $urandom_range(0, 4)));
            case (ph)
                0: write_reg(REG_BLEND, 64'd65536);
                1: write_reg(REG_BLEND, 64'h1FFFF);
                2: write_reg(REG_BLEND, 64'd0);
                3: write_reg(REG_BLEND, 64'd32768);
                4: write_reg(REG_BLEND, 64'd1);
                default: write_reg(REG_BLEND, {$urandom, $urandom});
            endcase
            write_reg(REG_FLIP, (ph % 2 == 0) ? {$urandom, $urandom} | 64'd1
                                               : {$urandom, $urandom} & ~64'd1);
            if (ph == 1)
                foreach (vertex_rows[i]) send_vertex(vertex_rows[i].v);
            for (int i = 0; i < 200; i++)
            begin
                send_vertex(random_vertex());
                // hold off until the pipe is empty, once
                if (ph == 4 && i == 100)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    wait (pending_vertices.size() == 0);
                end
                else if (ph % 3 != 2)
                    sender_gap();
            end
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/kvdb_pkg.sv
sv/kvdb_pos_lane.sv
sv/kvdb_norm_lane.sv
sv/keyframe_vertex_decode_blend.sv
tb/testbench.sv
